/* rtl/core/score_histogram_binner_macros.svh */
// Assertion helpers for the score histogram binner.
// Every macro expects clk and arst_n in scope.
`ifndef SCORE_HISTOGRAM_BINNER_MACROS_SVH
`define SCORE_HISTOGRAM_BINNER_MACROS_SVH

// Same-cycle implication.
`define SHB_ASSERT_IMP(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("shb: implication check failed");

// Next-cycle implication.
`define SHB_ASSERT_NEXT(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("shb: next-cycle check failed");

`endif

/* rtl/core/shb_pkg.sv */
package shb_pkg;

	localparam int NUM_BINS    = 128;
	localparam int COUNT_WIDTH = 32;
	localparam int IDX_W       = $clog2(NUM_BINS);

	// divider: 16-bit offset over a 15-bit width, one quotient bit per cycle
	localparam int DIV_N_W    = 16;
	localparam int DIV_D_W    = 15;
	localparam int DIV_CNT_W  = $clog2(DIV_N_W);

	localparam int CFG_IDX_W  = 8;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] REG_LOW_LIMIT   = 8'd0;
	localparam logic [CFG_IDX_W-1:0] REG_HIGH_LIMIT  = 8'd1;
	localparam logic [CFG_IDX_W-1:0] REG_BIN_WIDTH   = 8'd2;
	localparam logic [CFG_IDX_W-1:0] REG_BINS_IN_USE = 8'd3;

	localparam logic signed [15:0] LOW_LIMIT_RST   = -16'sd1280;
	localparam logic signed [15:0] HIGH_LIMIT_RST  = 16'sd1280;
	localparam logic [14:0]        BIN_WIDTH_RST   = 15'd26;
	localparam logic [7:0]         BINS_IN_USE_RST = 8'd98;

	localparam logic OP_ADD  = 1'b0;
	localparam logic OP_READ = 1'b1;

	typedef struct packed {
		logic               op;
		logic signed [15:0] sample;
		logic [6:0]         read_index;
	} shb_in_t;

	typedef struct packed {
		logic        accepted;
		logic [6:0]  hit_bin;
		logic [31:0] bin_value;
	} shb_out_t;

	typedef struct packed {
		logic               start;
		logic [DIV_N_W-1:0] dividend;
		logic [DIV_D_W-1:0] divisor;
	} shb_div_ctl_t;

	typedef struct packed {
		logic               done;
		logic [DIV_N_W-1:0] quotient;
	} shb_div_sts_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV,
		ST_RD,
		ST_RMW,
		ST_DONE
	} shb_state_t;

endpackage

/* rtl/core/shb_ram.sv */
module shb_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 128
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

/* rtl/core/shb_div.sv */
module shb_div
	import shb_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  shb_div_ctl_t ctl,
	output shb_div_sts_t sts
);

	logic                 busy_q;
	logic                 done_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [DIV_N_W-1:0]   quo_q;
	logic [DIV_D_W-1:0]   rem_q;
	logic [DIV_D_W-1:0]   div_q;

	logic [DIV_D_W:0]     trial;
	logic                 fits;
	logic [DIV_D_W:0]     diff;

	// restoring step: shift in next dividend bit, subtract if it fits
	always_comb begin
		trial = {rem_q, quo_q[DIV_N_W-1]};
		fits  = trial >= {1'b0, div_q};
		diff  = trial - {1'b0, div_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (ctl.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == DIV_CNT_W'(DIV_N_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			quo_q <= ctl.dividend;
			rem_q <= '0;
			div_q <= ctl.divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[DIV_N_W-2:0], fits};
			rem_q <= fits ? diff[DIV_D_W-1:0] : trial[DIV_D_W-1:0];
		end
	end

	assign sts.done     = done_q;
	assign sts.quotient = quo_q;

endmodule

/* rtl/core/score_histogram_binner.sv */
// Sequencing: a counted add runs 16 serial divide steps, the done handoff, one RAM read, one
// update and the output load; a read skips the divide; an add outside the window goes straight
// to the output load, and an add whose bin is past the bins in use skips the read and update.
// in_stall holds new items off while one is in flight; the next transfer is taken only once the
// result has loaded and the sequencer is back in idle, and a stalled output keeps it in ST_DONE.
// Reset (arst_n, async, active low): registers return to -1280, 1280, 26 and 98, and all
// bin valid bits clear at once, so every bin reads zero right away; no clearing pass.
`include "score_histogram_binner_macros.svh"

module score_histogram_binner
	import shb_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	// input items
	input  logic                  in_valid,
	output logic                  in_stall,
	input  shb_in_t               in_data,
	// results
	output logic                  out_valid,
	input  logic                  out_stall,
	output shb_out_t              out_data,
	// register writes
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	// ---------------------------------------------------------------
	// Configuration registers. Writes are always taken; software must
	// write only while the block is idle; the block does not enforce it.
	// ---------------------------------------------------------------
	logic signed [15:0] low_q;
	logic signed [15:0] high_q;
	logic [14:0]        width_q;
	logic [7:0]         bins_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			low_q   <= LOW_LIMIT_RST;
			high_q  <= HIGH_LIMIT_RST;
			width_q <= BIN_WIDTH_RST;
			bins_q  <= BINS_IN_USE_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_LOW_LIMIT:   low_q   <= $signed(cfg_data);
				REG_HIGH_LIMIT:  high_q  <= $signed(cfg_data);
				REG_BIN_WIDTH:   width_q <= cfg_data[14:0];
				REG_BINS_IN_USE: bins_q  <= cfg_data[7:0];
				default: ; // unknown index: ignored
			endcase
		end
	end

	// ---------------------------------------------------------------
	// Sequencer state and per-item registers
	// ---------------------------------------------------------------
	shb_state_t state_q, state_d;

	logic                   op_q;
	logic [IDX_W-1:0]       addr_q;
	shb_out_t               res_q;
	logic                   out_valid_q;
	shb_out_t               out_q;
	logic [NUM_BINS-1:0]    valid_q;

	logic                   in_fire;
	logic                   out_free;
	logic                   in_range;
	logic                   rd_ok;
	logic [16:0]            offset;
	logic [16:0]            limit;
	logic                   q_ok;

	shb_div_ctl_t           div_ctl;
	shb_div_sts_t           div_sts;

	logic                   ram_re;
	logic                   ram_we;
	logic [COUNT_WIDTH-1:0] ram_rdata;
	logic [COUNT_WIDTH-1:0] cnt_cur;
	logic [COUNT_WIDTH-1:0] cnt_next;

	assign in_stall  = (state_q != ST_IDLE);
	assign in_fire   = in_valid && !in_stall;
	// output register frees up when empty or when its transfer completes
	assign out_free  = !out_valid_q || !out_stall;

	// sample checks on the incoming payload
	always_comb begin
		in_range = (in_data.sample >= low_q) && (in_data.sample < high_q) &&
			(width_q != '0);
		offset   = {in_data.sample[15], in_data.sample} - {low_q[15], low_q};
		rd_ok    = 32'(in_data.read_index) < 32'(NUM_BINS);
	end

	// bins_in_use clamps to the store depth
	always_comb begin
		limit = (17'(bins_q) > 17'(NUM_BINS)) ? 17'(NUM_BINS) : 17'(bins_q);
		q_ok  = 17'(div_sts.quotient) < limit;
	end

	// a bin never written reads as zero; count saturates
	always_comb begin
		cnt_cur  = valid_q[addr_q] ? ram_rdata : '0;
		cnt_next = (cnt_cur == {COUNT_WIDTH{1'b1}}) ? cnt_cur : cnt_cur + 1'b1;
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_fire) begin
					if (in_data.op == OP_READ) begin
						state_d = rd_ok ? ST_RD : ST_DONE;
					end else begin
						state_d = in_range ? ST_DIV : ST_DONE;
					end
				end
			end
			ST_DIV: begin
				if (div_sts.done) begin
					state_d = q_ok ? ST_RD : ST_DONE;
				end
			end
			ST_RD:   state_d = ST_RMW;
			ST_RMW:  state_d = ST_DONE;
			ST_DONE: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		div_ctl.start    = (state_q == ST_IDLE) && in_fire &&
			(in_data.op == OP_ADD) && in_range;
		div_ctl.dividend = offset[15:0];
		div_ctl.divisor  = width_q;
		ram_re           = (state_q == ST_RD);
		ram_we           = (state_q == ST_RMW) && (op_q == OP_ADD);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
			valid_q     <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (ram_we) begin
				valid_q[addr_q] <= 1'b1;
			end
		end
	end

	// item payload
	always_ff @(posedge clk) begin
		if (in_fire) begin
			op_q   <= in_data.op;
			addr_q <= IDX_W'(in_data.read_index);
			res_q  <= '0;
		end
		if (state_q == ST_DIV && div_sts.done && q_ok) begin
			addr_q <= div_sts.quotient[IDX_W-1:0];
		end
		if (state_q == ST_RMW) begin
			if (op_q == OP_ADD) begin
				res_q.accepted  <= 1'b1;
				res_q.hit_bin   <= 7'(addr_q);
				res_q.bin_value <= 32'(cnt_next);
			end else begin
				res_q.bin_value <= 32'(cnt_cur);
			end
		end
		if (state_q == ST_DONE && out_free) begin
			out_q <= res_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// ---------------------------------------------------------------
	// Divider for adds; count store shared by adds and reads
	// ---------------------------------------------------------------
	shb_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (div_ctl),
		.sts    (div_sts)
	);

	shb_ram #(
		.WIDTH (COUNT_WIDTH),
		.DEPTH (NUM_BINS)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (addr_q),
		.wdata (cnt_next),
		.re    (ram_re),
		.raddr (addr_q),
		.rdata (ram_rdata)
	);

	// ---------------------------------------------------------------
	// Assertions
	// ---------------------------------------------------------------
	`SHB_ASSERT_IMP(a_div_done_in_div, div_sts.done, state_q == ST_DIV)
	`SHB_ASSERT_IMP(a_ram_we_on_add, ram_we, op_q == OP_ADD && state_q == ST_RMW)
	`SHB_ASSERT_NEXT(a_fire_leaves_idle, in_fire, state_q != ST_IDLE)
	`SHB_ASSERT_IMP(a_counted_nonzero, out_valid_q && out_q.accepted, out_q.bin_value != '0)

endmodule
